/* rtl/core/wwgl_pkg.sv */
// ----------------------------------------------------------------------------
// wwgl_pkg
// Shared types, codes and saturating helpers for the word wrap glyph layout.
// ----------------------------------------------------------------------------
package wwgl_pkg;

    // word length field, wide enough for word lengths up to 63
    localparam int CNT_W    = 6;
    localparam int CODE_W   = 21;
    localparam int METRIC_W = 32;

    localparam logic [CODE_W-1:0] CODE_TAB    = 21'd9;
    localparam logic [CODE_W-1:0] CODE_NL     = 21'd10;
    localparam logic [CODE_W-1:0] CODE_SPACE  = 21'd32;
    localparam logic [CODE_W-1:0] CODE_HYPHEN = 21'd45;

    localparam logic [1:0] CFG_BOUND_WIDTH = 2'd0;
    localparam logic [1:0] CFG_LINE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_LEFT = 2'd2;
    localparam logic [1:0] CFG_ORIGIN_TOP  = 2'd3;

    typedef enum logic [1:0] {
        CMD_PLACE  = 2'd0,
        CMD_BREAK  = 2'd1,
        CMD_FINISH = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               bank;
        logic [CNT_W-1:0]   count;
        logic signed [15:0] width;
        logic               lone;
        logic               item_end;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

    typedef struct packed {
        logic [14:0]        bound_width;
        logic [7:0]         line_height;
        logic signed [15:0] origin_left;
        logic signed [15:0] origin_top;
    } cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0]  glyph_code;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [14:0]        extent_x;
        logic [14:0]        extent_y;
        logic               is_glyph;
        logic               last;
    } res_t;

    function automatic logic signed [17:0] sx16(input logic signed [15:0] v);
        return {{2{v[15]}}, v};
    endfunction

    function automatic logic signed [17:0] sx8(input logic [7:0] v);
        return {{10{v[7]}}, v};
    endfunction

    function automatic logic signed [17:0] zx8(input logic [7:0] v);
        return {10'b0, v};
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            return 16'sh7fff;
        end
        else if (v < -18'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic logic [14:0] clamp15(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            return 15'h7fff;
        end
        else if (v < 18'sd0) begin
            return 15'h0000;
        end
        return v[14:0];
    endfunction

endpackage

/* rtl/core/wwgl_ram.sv */
// ----------------------------------------------------------------------------
// wwgl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module wwgl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/core/wwgl_cmd_queue.sv */
// ----------------------------------------------------------------------------
// wwgl_cmd_queue
// Two entry command queue between the classifying front and the placing back.
// ----------------------------------------------------------------------------
module wwgl_cmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  wwgl_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output wwgl_pkg::cmd_t  head,
    output logic            empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    wwgl_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (fill_reg == FILL_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/core/wwgl_front.sv */
// ----------------------------------------------------------------------------
// wwgl_front
// Accepts characters, classifies them, builds words in a two bank buffer and
// queues place, line break and finish commands for the back.
// ----------------------------------------------------------------------------
module wwgl_front #(
    parameter int WORD_MAX = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [20:0]                code_point,
    input  logic signed [7:0]          lead_bearing,
    input  logic [7:0]                 body_advance,
    input  logic signed [7:0]          trail_bearing,
    input  logic [7:0]                 glyph_width,
    input  logic                       end_of_text,
    output logic                       q_push,
    output wwgl_pkg::cmd_t             q_cmd,
    input  logic                       q_full,
    input  wwgl_pkg::rel_t             rel,
    output logic                       wr_en,
    output logic [$clog2(WORD_MAX):0]  wr_addr,
    output logic [20:0]                wr_code,
    output logic [31:0]                wr_metrics
);

    localparam int IDX_W = $clog2(WORD_MAX);
    localparam int CNT_W = wwgl_pkg::CNT_W;

    typedef enum logic [4:0] {
        F_IDLE  = 5'b00001,
        F_FLUSH = 5'b00010,
        F_PUSH  = 5'b00100,
        F_LAST  = 5'b01000,
        F_TAIL  = 5'b10000
    } front_state_t;

    typedef enum logic [2:0] {
        K_PLAIN,
        K_HYPHEN,
        K_SPACE,
        K_NEWLINE,
        K_END
    } item_kind_t;

    front_state_t       state_reg, state_next;
    item_kind_t         kind_reg, kind_next, kind_in;
    logic [20:0]        code_reg, code_next;
    logic [31:0]        metrics_reg, metrics_next;
    logic [CNT_W-1:0]   count_reg, count_next, count_inc;
    logic signed [15:0] width_reg, width_next, width_sum;
    logic               bank_reg, bank_next;
    logic [1:0]         busy_reg, busy_next;
    front_state_t       after_flush;

    always_comb
    begin
        if (end_of_text)
        begin
            kind_in = K_END;
        end
        else
        begin
            unique case (code_point) inside
                wwgl_pkg::CODE_NL:                      kind_in = K_NEWLINE;
                wwgl_pkg::CODE_SPACE, wwgl_pkg::CODE_TAB: kind_in = K_SPACE;
                wwgl_pkg::CODE_HYPHEN:                  kind_in = K_HYPHEN;
                default:                                kind_in = K_PLAIN;
            endcase
        end
    end

    assign in_ready   = (state_reg == F_IDLE);
    assign count_inc  = count_reg + CNT_W'(1);
    assign width_sum  = wwgl_pkg::sat16(wwgl_pkg::sx16(width_reg)
                                      + wwgl_pkg::sx8(metrics_reg[7:0])
                                      + wwgl_pkg::zx8(metrics_reg[15:8])
                                      + wwgl_pkg::sx8(metrics_reg[23:16]));
    assign after_flush = (kind_reg == K_SPACE) ? F_PUSH : F_TAIL;

    assign wr_addr    = {bank_reg, count_reg[IDX_W-1:0]};
    assign wr_code    = code_reg;
    assign wr_metrics = metrics_reg;

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        code_next    = code_reg;
        metrics_next = metrics_reg;
        count_next   = count_reg;
        width_next   = width_reg;
        bank_next    = bank_reg;
        busy_next    = busy_reg;
        q_push       = 1'b0;
        q_cmd        = '0;
        wr_en        = 1'b0;

        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end

        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next    = kind_in;
                    code_next    = code_point;
                    metrics_next = {glyph_width, trail_bearing, body_advance, lead_bearing};
                    if (kind_in == K_END || kind_in == K_NEWLINE || kind_in == K_SPACE)
                    begin
                        state_next = F_FLUSH;
                    end
                    else
                    begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_FLUSH:
            begin
                if (count_reg == '0)
                begin
                    state_next = after_flush;
                end
                else if (!q_full)
                begin
                    // pending word never holds a space, so it is never lone
                    q_push              = 1'b1;
                    q_cmd.kind          = wwgl_pkg::CMD_PLACE;
                    q_cmd.bank          = bank_reg;
                    q_cmd.count         = count_reg;
                    q_cmd.width         = width_reg;
                    busy_next[bank_reg] = 1'b1;
                    bank_next           = ~bank_reg;
                    count_next          = '0;
                    width_next          = '0;
                    state_next          = after_flush;
                end
            end
            F_PUSH:
            begin
                if (!busy_reg[bank_reg])
                begin
                    wr_en      = 1'b1;
                    count_next = count_inc;
                    width_next = width_sum;
                    if (kind_reg == K_SPACE || kind_reg == K_HYPHEN
                        || count_inc == CNT_W'(WORD_MAX))
                    begin
                        state_next = F_LAST;
                    end
                    else
                    begin
                        state_next = F_IDLE;
                    end
                end
            end
            F_LAST:
            begin
                if (!q_full)
                begin
                    q_push              = 1'b1;
                    q_cmd.kind          = wwgl_pkg::CMD_PLACE;
                    q_cmd.bank          = bank_reg;
                    q_cmd.count         = count_reg;
                    q_cmd.width         = width_reg;
                    q_cmd.lone          = (count_reg == CNT_W'(1))
                                       && (code_reg == wwgl_pkg::CODE_SPACE);
                    q_cmd.item_end      = 1'b1;
                    busy_next[bank_reg] = 1'b1;
                    bank_next           = ~bank_reg;
                    count_next          = '0;
                    width_next          = '0;
                    state_next          = F_IDLE;
                end
            end
            F_TAIL:
            begin
                if (!q_full)
                begin
                    q_push         = 1'b1;
                    q_cmd.kind     = (kind_reg == K_END) ? wwgl_pkg::CMD_FINISH
                                                         : wwgl_pkg::CMD_BREAK;
                    q_cmd.item_end = 1'b1;
                    state_next     = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            count_reg <= '0;
            width_reg <= '0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            width_reg <= width_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        code_reg    <= code_next;
        metrics_reg <= metrics_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WORD_MAX))
        else $error("word count beyond buffer size");

    a_place_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_cmd.kind == wwgl_pkg::CMD_PLACE)
        |-> (q_cmd.count != '0 && !busy_reg[q_cmd.bank]))
        else $error("place command for empty or busy bank");

    a_bank_handover: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_full && q_cmd.kind == wwgl_pkg::CMD_PLACE)
        |=> (busy_reg[$past(bank_reg)] && bank_reg != $past(bank_reg)
             && count_reg == '0))
        else $error("bank not handed over after place");

endmodule

/* rtl/core/wwgl_back.sv */
// ----------------------------------------------------------------------------
// wwgl_back
// Carries out queued commands: wrap decision, glyph placement from the word
// buffer, extents, and the result stage that marks the last beat of an item.
// ----------------------------------------------------------------------------
module wwgl_back #(
    parameter int WORD_MAX = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wwgl_pkg::cfg_t             cfg,
    output logic                       q_pop,
    input  wwgl_pkg::cmd_t             q_cmd,
    input  logic                       q_empty,
    output wwgl_pkg::rel_t             rel,
    output logic [$clog2(WORD_MAX):0]  rd_addr,
    input  logic [20:0]                rd_code,
    input  logic [31:0]                rd_metrics,
    output logic                       out_valid,
    input  logic                       out_ready,
    output wwgl_pkg::res_t             out_res
);

    localparam int IDX_W = $clog2(WORD_MAX);
    localparam int CNT_W = wwgl_pkg::CNT_W;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_CMD  = 5'b00010,
        B_LOAD = 5'b00100,
        B_EMIT = 5'b01000,
        B_END  = 5'b10000
    } back_state_t;

    back_state_t        state_reg, state_next, end_state;
    wwgl_pkg::cmd_t     cmd_reg, cmd_next;
    logic [IDX_W-1:0]   idx_reg, idx_next, idx_inc;
    logic [IDX_W:0]     rd_addr_reg, rd_addr_next;
    logic signed [15:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [14:0]        mx_reg, mx_next, my_reg, my_next;
    logic               out_v_reg, out_v_next, hold_v_reg, hold_v_next;
    wwgl_pkg::res_t     out_res_reg, out_res_next, hold_res_reg, hold_res_next;
    wwgl_pkg::res_t     res_new;
    logic               produce, flush, slot_ok, wrap, last_glyph;
    logic signed [17:0] wrap_sum;
    logic signed [15:0] brk_y, cx_pre, cx_adv, px, py;
    logic [14:0]        ex, ey, mx_new, my_new;
    logic [7:0]         lead, body, trail, gw, lead_pos;

    assign lead     = rd_metrics[7:0];
    assign body     = rd_metrics[15:8];
    assign trail    = rd_metrics[23:16];
    assign gw       = rd_metrics[31:24];
    assign lead_pos = lead[7] ? 8'd0 : lead;

    assign wrap_sum = wwgl_pkg::sx16(cx_reg) + wwgl_pkg::sx16(cmd_reg.width);
    assign wrap     = (cfg.bound_width != '0) && (cx_reg > 16'sd0)
                   && (wrap_sum > $signed({3'b000, cfg.bound_width}));
    assign brk_y    = wwgl_pkg::sat16(wwgl_pkg::sx16(cy_reg)
                                    + wwgl_pkg::zx8(cfg.line_height));

    // left overhang pulls the cursor back before the glyph is placed
    assign cx_pre = lead[7] ? wwgl_pkg::sat16(wwgl_pkg::sx16(cx_reg) + wwgl_pkg::sx8(lead))
                            : cx_reg;
    assign ex     = wwgl_pkg::clamp15(wwgl_pkg::sx16(cx_reg) + wwgl_pkg::zx8(gw));
    assign ey     = wwgl_pkg::clamp15(wwgl_pkg::sx16(cy_reg)
                                    + wwgl_pkg::zx8(cfg.line_height) + 18'sd1);
    assign mx_new = (ex > mx_reg) ? ex : mx_reg;
    assign my_new = (ey > my_reg) ? ey : my_reg;
    assign px     = wwgl_pkg::sat16(wwgl_pkg::sx16(cfg.origin_left)
                                  + wwgl_pkg::sx16(cx_reg) - 18'sd1);
    assign py     = wwgl_pkg::sat16(wwgl_pkg::sx16(cfg.origin_top)
                                  + wwgl_pkg::sx16(cy_reg) - 18'sd1);
    assign cx_adv = wwgl_pkg::sat16(wwgl_pkg::sx16(cx_reg) + wwgl_pkg::zx8(lead_pos)
                                  + wwgl_pkg::zx8(body) + wwgl_pkg::sx8(trail));

    assign idx_inc    = idx_reg + IDX_W'(1);
    assign last_glyph = ((CNT_W'(idx_reg) + CNT_W'(1)) == cmd_reg.count);
    assign slot_ok    = !hold_v_reg || !out_v_reg || out_ready;
    assign end_state  = cmd_reg.item_end ? B_END : B_IDLE;

    assign rd_addr   = rd_addr_next;
    assign out_valid = out_v_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        rd_addr_next  = rd_addr_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        mx_next       = mx_reg;
        my_next       = my_reg;
        out_v_next    = out_v_reg;
        out_res_next  = out_res_reg;
        hold_v_next   = hold_v_reg;
        hold_res_next = hold_res_reg;
        q_pop         = 1'b0;
        rel           = '0;
        produce       = 1'b0;
        flush         = 1'b0;
        res_new       = '0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = B_CMD;
                end
            end
            B_CMD:
            begin
                unique case (cmd_reg.kind)
                    wwgl_pkg::CMD_PLACE:
                    begin
                        if (wrap)
                        begin
                            cx_next = '0;
                            cy_next = brk_y;
                        end
                        // a lone space that wraps is dropped after the line advance
                        if (wrap && cmd_reg.lone)
                        begin
                            rel.valid  = 1'b1;
                            rel.bank   = cmd_reg.bank;
                            state_next = end_state;
                        end
                        else
                        begin
                            idx_next     = '0;
                            rd_addr_next = {cmd_reg.bank, IDX_W'(0)};
                            state_next   = B_LOAD;
                        end
                    end
                    wwgl_pkg::CMD_BREAK:
                    begin
                        cx_next    = '0;
                        cy_next    = brk_y;
                        state_next = end_state;
                    end
                    wwgl_pkg::CMD_FINISH:
                    begin
                        if (slot_ok)
                        begin
                            produce          = 1'b1;
                            res_new.extent_x = mx_reg;
                            res_new.extent_y = my_reg;
                            cx_next          = '0;
                            cy_next          = '0;
                            mx_next          = '0;
                            my_next          = '0;
                            state_next       = end_state;
                        end
                    end
                    default:
                    begin
                        state_next = B_IDLE;
                    end
                endcase
            end
            B_LOAD:
            begin
                cx_next    = cx_pre;
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (slot_ok)
                begin
                    produce            = 1'b1;
                    res_new.glyph_code = rd_code;
                    res_new.pos_x      = px;
                    res_new.pos_y      = py;
                    res_new.extent_x   = mx_new;
                    res_new.extent_y   = my_new;
                    res_new.is_glyph   = 1'b1;
                    mx_next            = mx_new;
                    my_next            = my_new;
                    cx_next            = cx_adv;
                    if (last_glyph)
                    begin
                        rel.valid  = 1'b1;
                        rel.bank   = cmd_reg.bank;
                        state_next = end_state;
                    end
                    else
                    begin
                        idx_next     = idx_inc;
                        rd_addr_next = {cmd_reg.bank, idx_inc};
                        state_next   = B_LOAD;
                    end
                end
            end
            B_END:
            begin
                if (!hold_v_reg)
                begin
                    state_next = B_IDLE;
                end
                else if (!out_v_reg || out_ready)
                begin
                    flush      = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        // result waits in the hold stage until it is known whether it ends the item
        if (out_v_reg && out_ready)
        begin
            out_v_next = 1'b0;
        end
        if (produce)
        begin
            if (hold_v_reg)
            begin
                out_res_next = hold_res_reg;
                out_v_next   = 1'b1;
            end
            hold_res_next = res_new;
            hold_v_next   = 1'b1;
        end
        if (flush)
        begin
            out_res_next      = hold_res_reg;
            out_res_next.last = 1'b1;
            out_v_next        = 1'b1;
            hold_v_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            cx_reg     <= '0;
            cy_reg     <= '0;
            mx_reg     <= '0;
            my_reg     <= '0;
            out_v_reg  <= 1'b0;
            hold_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            mx_reg     <= mx_next;
            my_reg     <= my_next;
            out_v_reg  <= out_v_next;
            hold_v_reg <= hold_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        rd_addr_reg  <= rd_addr_next;
        out_res_reg  <= out_res_next;
        hold_res_reg <= hold_res_next;
    end

    a_terminal_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_res_reg.is_glyph) |-> out_res_reg.last)
        else $error("terminal result not marked last");

    a_idx_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_LOAD || state_reg == B_EMIT)
        |-> (CNT_W'(idx_reg) < cmd_reg.count))
        else $error("glyph index past end of word");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CMD && cmd_reg.kind == wwgl_pkg::CMD_FINISH && slot_ok)
        |=> (cx_reg == '0 && cy_reg == '0 && mx_reg == '0 && my_reg == '0
             && state_reg == B_END && hold_v_reg))
        else $error("finish did not clear layout state");

endmodule

/* rtl/core/word_wrap_glyph_layout.sv */
// ----------------------------------------------------------------------------
// word_wrap_glyph_layout
// Greedy word wrap layout of a stream of glyphs with running extents.
// ----------------------------------------------------------------------------
// A plain character is accepted in the front and then written into the word
// buffer. The back pops every command from the queue and then decodes it with
// the wrap decision, and for each glyph of a word it reads the buffer with the
// overhang step and then emits the glyph; the command that ends an item then
// passes through an end state that marks its last beat. The result side can
// stall the back. The back's read-and-emit loop over the two bank word buffer
// sets the sustained rate, and the front keeps building the next word in the
// other bank while the back places the current one. An end of text item
// flushes the pending word, gives one terminal beat with the extents and
// returns the cursor to the origin. No clearing pass runs after reset.
module word_wrap_glyph_layout #(
    parameter int WORD_MAX = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [20:0]        code_point,
    input  logic signed [7:0]  lead_bearing,
    input  logic [7:0]         body_advance,
    input  logic signed [7:0]  trail_bearing,
    input  logic [7:0]         glyph_width,
    input  logic               end_of_text,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [20:0]        glyph_code,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic [14:0]        extent_x,
    output logic [14:0]        extent_y,
    output logic               is_glyph,
    output logic               last,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int IDX_W     = $clog2(WORD_MAX);
    localparam int BUF_DEPTH = 2 ** (IDX_W + 1);

    wwgl_pkg::cfg_t  cfg_reg;
    wwgl_pkg::cmd_t  push_cmd, head_cmd;
    wwgl_pkg::rel_t  rel;
    wwgl_pkg::res_t  res;
    logic            q_push, q_full, q_pop, q_empty;
    logic            wr_en;
    logic [IDX_W:0]  wr_addr, rd_addr;
    logic [20:0]     wr_code, rd_code;
    logic [31:0]     wr_metrics, rd_metrics;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bound_width <= '0;
            cfg_reg.line_height <= 8'd16;
            cfg_reg.origin_left <= '0;
            cfg_reg.origin_top  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wwgl_pkg::CFG_BOUND_WIDTH: cfg_reg.bound_width <= cfg_data[14:0];
                wwgl_pkg::CFG_LINE_HEIGHT: cfg_reg.line_height <= cfg_data[7:0];
                wwgl_pkg::CFG_ORIGIN_LEFT: cfg_reg.origin_left <= cfg_data;
                wwgl_pkg::CFG_ORIGIN_TOP:  cfg_reg.origin_top  <= cfg_data;
                default:                   cfg_reg.origin_top  <= cfg_reg.origin_top;
            endcase
        end
    end

    wwgl_front #(
        .WORD_MAX (WORD_MAX)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .code_point    (code_point),
        .lead_bearing  (lead_bearing),
        .body_advance  (body_advance),
        .trail_bearing (trail_bearing),
        .glyph_width   (glyph_width),
        .end_of_text   (end_of_text),
        .q_push        (q_push),
        .q_cmd         (push_cmd),
        .q_full        (q_full),
        .rel           (rel),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_code       (wr_code),
        .wr_metrics    (wr_metrics)
    );

    wwgl_ram #(
        .WIDTH (21),
        .DEPTH (BUF_DEPTH)
    ) u_code_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_code),
        .rd_addr (rd_addr),
        .rd_data (rd_code)
    );

    wwgl_ram #(
        .WIDTH (32),
        .DEPTH (BUF_DEPTH)
    ) u_metric_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_metrics),
        .rd_addr (rd_addr),
        .rd_data (rd_metrics)
    );

    wwgl_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head_cmd),
        .empty    (q_empty)
    );

    wwgl_back #(
        .WORD_MAX (WORD_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_pop      (q_pop),
        .q_cmd      (head_cmd),
        .q_empty    (q_empty),
        .rel        (rel),
        .rd_addr    (rd_addr),
        .rd_code    (rd_code),
        .rd_metrics (rd_metrics),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_res    (res)
    );

    assign glyph_code = res.glyph_code;
    assign pos_x      = res.pos_x;
    assign pos_y      = res.pos_y;
    assign extent_x   = res.extent_x;
    assign extent_y   = res.extent_y;
    assign is_glyph   = res.is_glyph;
    assign last       = res.last;

endmodule
